[design/zbf_pkg.sv]
package zbf_pkg;

    // Width of a frame dimension as held in the configuration registers.
    localparam int DIM_W = 9;

    // Width used for address sums before they are cut to the store address.
    localparam int WIDE_W = 21;

    typedef enum logic [1:0] {
        OP_CLEAR_ALL   = 2'd0,
        OP_CLEAR_DEPTH = 2'd1,
        OP_BOX_FILL    = 2'd2,
        OP_READ        = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic [9:0]         box_width;
        logic [9:0]         box_height;
        logic [7:0]         pixel_color;
        logic signed [31:0] depth_value;
    } item_t;

    typedef struct packed {
        logic               rejected;
        logic [7:0]         read_color;
        logic signed [31:0] read_depth;
    } res_t;

    typedef struct packed {
        logic color_we;
        logic depth_we;
        logic rd_en;
    } store_ctl_t;

    // Frame dimension in use: zero counts as one, above the maximum saturates.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [10:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end
        else if ({2'b00, v} > maxv) begin
            r = maxv[DIM_W-1:0];
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[design/zbf_store.sv]
module zbf_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                  clk,
    input  zbf_pkg::store_ctl_t   ctl,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [7:0]            wr_color,
    input  logic signed [31:0]    wr_depth,
    output logic [7:0]            rd_color,
    output logic signed [31:0]    rd_depth
);

    logic [7:0]  color_mem [DEPTH];
    logic [31:0] depth_mem [DEPTH];

    // Colour store: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.color_we) begin
            color_mem[addr] <= wr_color;
        end
        if (ctl.rd_en) begin
            rd_color <= color_mem[addr];
        end
    end

    // Depth store, same port arrangement.
    always_ff @(posedge clk)
    begin
        if (ctl.depth_we) begin
            depth_mem[addr] <= wr_depth;
        end
        if (ctl.rd_en) begin
            rd_depth <= depth_mem[addr];
        end
    end

endmodule

[design/zbf_seq.sv]
module zbf_seq #(
    parameter int ADDR_W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  zbf_pkg::item_t              item,
    input  logic [zbf_pkg::DIM_W-1:0]   frame_w,
    input  logic [zbf_pkg::DIM_W-1:0]   frame_h,
    input  logic                        out_free,
    output logic                        idle,
    output logic                        done,
    output zbf_pkg::res_t               result,
    output zbf_pkg::store_ctl_t         store_ctl,
    output logic [ADDR_W-1:0]           store_addr,
    output logic [7:0]                  store_color,
    output logic signed [31:0]          store_depth,
    input  logic [7:0]                  rd_color,
    input  logic signed [31:0]          rd_depth
);

    localparam int DW = zbf_pkg::DIM_W;
    localparam int WW = zbf_pkg::WIDE_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLIP  = 7'b0000010,
        ST_BASE  = 7'b0000100,
        ST_CLEAR = 7'b0001000,
        ST_RD    = 7'b0010000,
        ST_CMP   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    zbf_pkg::item_t      item_reg;
    zbf_pkg::res_t       res_reg, res_next;
    logic [DW-1:0]       x0_reg, x0_next;
    logic [DW-1:0]       y0_reg, y0_next;
    logic [DW-1:0]       col_last_reg, col_last_next;
    logic [DW-1:0]       row_last_reg, row_last_next;
    logic [DW-1:0]       col_reg, col_next;
    logic [DW-1:0]       row_reg, row_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   last_reg, last_next;

    // Clip arithmetic on signed values wide enough for every sum.
    logic signed [12:0]  xs, ys, ws, hs, wd, ht, xe, ye, w1, h1, wf, hf;
    logic                rej, empty, in_frame;

    // Shared multiplier: frame width times a row count or a row index.
    logic [DW-1:0]       mul_a;
    logic [2*DW-1:0]     prod;
    logic [WW-1:0]       row_addr;
    logic [ADDR_W-1:0]   next_base;
    logic                closer;

    always_comb
    begin
        xs = {{2{item_reg.pos_x[10]}}, item_reg.pos_x};
        ys = {{2{item_reg.pos_y[10]}}, item_reg.pos_y};
        ws = {3'b000, item_reg.box_width};
        hs = {3'b000, item_reg.box_height};
        wd = {4'b0000, frame_w};
        ht = {4'b0000, frame_h};
        xe = xs + ws;
        ye = ys + hs;
        rej = (xs >= wd) || (ys >= ht) || (xe < 0) || (ye < 0);
        w1 = (xe >= wd) ? (wd - 13'sd1 - xs) : ws;
        h1 = (ye >= ht) ? (ht - 13'sd1 - ys) : hs;
        wf = (xs < 0) ? (w1 + xs) : w1;
        hf = (ys < 0) ? (h1 + ys) : h1;
        empty = (wf <= 0) || (hf <= 0);
        in_frame = (xs >= 0) && (ys >= 0) && (xs < wd) && (ys < ht);
    end

    assign mul_a     = (item_reg.op == zbf_pkg::OP_BOX_FILL || item_reg.op == zbf_pkg::OP_READ)
                       ? y0_reg : frame_h;
    assign prod      = frame_w * mul_a;
    assign row_addr  = WW'(prod) + WW'(x0_reg);
    assign next_base = ADDR_W'(WW'(base_reg) + WW'(frame_w));
    assign closer    = rd_depth > item_reg.depth_value;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        x0_next       = x0_reg;
        y0_next       = y0_reg;
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        addr_next     = addr_reg;
        last_next     = last_reg;
        store_ctl     = '0;
        done          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = ST_CLIP;
                end
            end

            ST_CLIP:
            begin
                res_next = '0;
                col_next = '0;
                row_next = '0;
                unique case (item_reg.op)
                    zbf_pkg::OP_CLEAR_ALL,
                    zbf_pkg::OP_CLEAR_DEPTH:
                    begin
                        state_next = ST_BASE;
                    end
                    zbf_pkg::OP_BOX_FILL:
                    begin
                        x0_next       = (xs < 0) ? '0 : xs[DW-1:0];
                        y0_next       = (ys < 0) ? '0 : ys[DW-1:0];
                        col_last_next = DW'(wf - 13'sd1);
                        row_last_next = DW'(hf - 13'sd1);
                        res_next.rejected = rej;
                        state_next = (rej || empty) ? ST_DONE : ST_BASE;
                    end
                    zbf_pkg::OP_READ:
                    begin
                        x0_next    = xs[DW-1:0];
                        y0_next    = ys[DW-1:0];
                        state_next = in_frame ? ST_BASE : ST_DONE;
                    end
                endcase
            end

            ST_BASE:
            begin
                base_next = ADDR_W'(prod);
                if (item_reg.op == zbf_pkg::OP_BOX_FILL || item_reg.op == zbf_pkg::OP_READ) begin
                    addr_next  = ADDR_W'(row_addr);
                    state_next = ST_RD;
                end
                else begin
                    addr_next  = '0;
                    last_next  = ADDR_W'(WW'(prod) - WW'(1));
                    state_next = ST_CLEAR;
                end
            end

            ST_CLEAR:
            begin
                store_ctl.depth_we = 1'b1;
                store_ctl.color_we = (item_reg.op == zbf_pkg::OP_CLEAR_ALL);
                if (addr_reg == last_reg) begin
                    state_next = ST_DONE;
                end
                else begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            ST_RD:
            begin
                store_ctl.rd_en = 1'b1;
                state_next      = ST_CMP;
            end

            ST_CMP:
            begin
                if (item_reg.op == zbf_pkg::OP_READ) begin
                    res_next.read_color = rd_color;
                    res_next.read_depth = rd_depth;
                    state_next          = ST_DONE;
                end
                else begin
                    // Depth test: write only where the new depth is nearer.
                    store_ctl.color_we = closer;
                    store_ctl.depth_we = closer;
                    state_next         = ST_RD;
                    if (col_reg == col_last_reg) begin
                        col_next = '0;
                        if (row_reg == row_last_reg) begin
                            state_next = ST_DONE;
                        end
                        else begin
                            row_next  = row_reg + DW'(1);
                            base_next = next_base;
                            addr_next = ADDR_W'(WW'(next_base) + WW'(x0_reg));
                        end
                    end
                    else begin
                        col_next  = col_reg + DW'(1);
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Working registers and the latched request.
    always_ff @(posedge clk)
    begin
        if (start && state_reg == ST_IDLE) begin
            item_reg <= item;
        end
        res_reg      <= res_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        col_last_reg <= col_last_next;
        row_last_reg <= row_last_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        base_reg     <= base_next;
        addr_reg     <= addr_next;
        last_reg     <= last_next;
    end

    assign idle        = (state_reg == ST_IDLE);
    assign result      = res_reg;
    assign store_addr  = addr_reg;
    assign store_color = item_reg.pixel_color;
    assign store_depth = item_reg.depth_value;

endmodule

[design/zbuffered_box_fill.sv]
// Depth-buffered box fill over a colour store and a depth store.
// Requests arrive on the s_ channel, one operation each: clear all, clear
// depth, box fill with clipping, or read one entry. Every request yields one
// result on the m_ channel. Frame width and height are set through the cfg_
// channel, which is always ready; it is to be written only while the block is
// idle; the block does not enforce this. Work from acceptance to result:
//   clear all / clear depth : one store write per cycle over the W*H entries.
//   box fill                : each pixel of the clipped box takes a store
//                             read then a compare and write on the single
//                             store port; a rejected or empty box does not
//                             touch the store.
//   read                    : one store read inside the frame, none outside.
// s_tready is low while a request is being worked on. The result sits in an
// output register, so a new request is accepted while it waits; if the
// receiver stalls, the next request finishes its work and then holds until
// the output register is free. Reset empties the output register, returns
// the sequencer to idle and sets both frame dimensions to 256. The stores
// are not cleared by reset and must be written before they are read.
module zbuffered_box_fill #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata fields from bit 0: operation[1:0], pos_x[12:2], pos_y[23:13],
    // box_width[33:24], box_height[43:34], pixel_color[51:44],
    // depth_value[83:52], zero fill[87:84].
    input  logic [87:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0: rejected[0], read_color[8:1],
    // read_depth[40:9], zero fill[47:41].
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DW          = zbf_pkg::DIM_W;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    logic [DW-1:0]          frame_width_reg, frame_height_reg;
    logic [DW-1:0]          frame_w, frame_h;
    logic                   m_valid_reg;
    zbf_pkg::res_t          m_res_reg;
    zbf_pkg::item_t         item;
    zbf_pkg::res_t          result;
    zbf_pkg::store_ctl_t    store_ctl;
    logic [ADDR_W-1:0]      store_addr;
    logic [7:0]             store_color, rd_color;
    logic signed [31:0]     store_depth, rd_depth;
    logic                   seq_idle, seq_done, out_free, start;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_width_reg  <= DW'(256);
            frame_height_reg <= DW'(256);
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    assign frame_w = zbf_pkg::eff_dim(frame_width_reg, 11'(MAX_WIDTH));
    assign frame_h = zbf_pkg::eff_dim(frame_height_reg, 11'(MAX_HEIGHT));

    // Unpack the request.
    assign item.op          = zbf_pkg::op_t'(s_tdata[1:0]);
    assign item.pos_x       = s_tdata[12:2];
    assign item.pos_y       = s_tdata[23:13];
    assign item.box_width   = s_tdata[33:24];
    assign item.box_height  = s_tdata[43:34];
    assign item.pixel_color = s_tdata[51:44];
    assign item.depth_value = s_tdata[83:52];

    assign s_tready = seq_idle;
    assign start    = s_tvalid && seq_idle;
    assign out_free = !m_valid_reg || m_tready;

    zbf_seq #(
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .frame_w     (frame_w),
        .frame_h     (frame_h),
        .out_free    (out_free),
        .idle        (seq_idle),
        .done        (seq_done),
        .result      (result),
        .store_ctl   (store_ctl),
        .store_addr  (store_addr),
        .store_color (store_color),
        .store_depth (store_depth),
        .rd_color    (rd_color),
        .rd_depth    (rd_depth)
    );

    zbf_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .ctl      (store_ctl),
        .addr     (store_addr),
        .wr_color (store_color),
        .wr_depth (store_depth),
        .rd_color (rd_color),
        .rd_depth (rd_depth)
    );

    // Output register: holds a finished result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
        end
        else if (seq_done) begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done) begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_res_reg.read_depth, m_res_reg.read_color,
                       m_res_reg.rejected};

endmodule

[tb/sv/tb_zbuffered_box_fill.sv]
`timescale 1ns / 1ps

module tb_zbuffered_box_fill;

    localparam int FRAME_MAX_W = 256;
    localparam int FRAME_MAX_H = 256;
    localparam int STORE_WORDS = FRAME_MAX_W * FRAME_MAX_H;
    localparam int MAX_REPORTS = 10;
    // Frames above this many entries get no clears and only narrow boxes, to bound run time.
    localparam int WIDE_FRAME_ENTRIES = 4096;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Shadow of both stores and the frame registers, plus the queue of results still owed.
    class zbuffer_scoreboard;
        logic [7:0]         color_mem [STORE_WORDS];
        logic signed [31:0] depth_mem [STORE_WORDS];
        logic [8:0]         width_reg;
        logic [8:0]         height_reg;
        zbf_pkg::res_t      pending_results [$];
        int                 failures;

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            failures   = 0;
            foreach (color_mem[i])
            begin
                color_mem[i] = '0;
                depth_mem[i] = '0;
            end
        endfunction

        // A dimension of zero counts as one; anything above the maximum saturates.
        function int frame_dim(logic [8:0] v, int maxv);
            if (v == '0)
                return 1;
            if (int'(v) > maxv)
                return maxv;
            return int'(v);
        endfunction

        function void set_register(logic idx, logic [8:0] val);
            if (idx == REG_FRAME_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        // Applies one request to the shadow stores and returns the result it yields.
        function zbf_pkg::res_t zbuffer_apply(zbf_pkg::item_t req);
            int            fw, fh, x, y, w, h, addr, r, c;
            zbf_pkg::res_t res;
            fw  = frame_dim(width_reg, FRAME_MAX_W);
            fh  = frame_dim(height_reg, FRAME_MAX_H);
            x   = $signed(req.pos_x);
            y   = $signed(req.pos_y);
            w   = int'(req.box_width);
            h   = int'(req.box_height);
            res = '0;
            case (req.op)
                zbf_pkg::OP_CLEAR_ALL, zbf_pkg::OP_CLEAR_DEPTH:
                begin
                    for (addr = 0; addr < fw * fh; addr++)
                    begin
                        if (req.op == zbf_pkg::OP_CLEAR_ALL)
                            color_mem[addr] = req.pixel_color;
                        depth_mem[addr] = req.depth_value;
                    end
                end
                zbf_pkg::OP_BOX_FILL:
                begin
                    if (x >= fw || y >= fh || x + w < 0 || y + h < 0)
                    begin
                        res.rejected = 1'b1;
                    end
                    else
                    begin
                        // The far edge is clipped one short, so the last column
                        // and row stay untouched.
                        if (x + w >= fw)
                            w = fw - 1 - x;
                        if (y + h >= fh)
                            h = fh - 1 - y;
                        if (x < 0)
                        begin
                            w = w + x;
                            x = 0;
                        end
                        if (y < 0)
                        begin
                            h = h + y;
                            y = 0;
                        end
                        for (r = 0; r < h; r++)
                        begin
                            for (c = 0; c < w; c++)
                            begin
                                addr = (x + c) + fw * (y + r);
                                if ($signed(req.depth_value) < depth_mem[addr])
                                begin
                                    color_mem[addr] = req.pixel_color;
                                    depth_mem[addr] = req.depth_value;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    // A read outside the frame answers zero.
                    if (x >= 0 && y >= 0 && x < fw && y < fh)
                    begin
                        addr           = x + fw * y;
                        res.read_color = color_mem[addr];
                        res.read_depth = depth_mem[addr];
                    end
                end
            endcase
            return res;
        endfunction

        function void note_request(zbf_pkg::item_t req);
            pending_results.push_back(zbuffer_apply(req));
        endfunction

        function void report_failure(string what, zbf_pkg::res_t want, zbf_pkg::res_t got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s: expected rej=%0b col=%02h dep=%08h, got rej=%0b col=%02h dep=%08h",
                         what, want.rejected, want.read_color, want.read_depth,
                         got.rejected, got.read_color, got.read_depth);
        endfunction

        function void check_result(logic [47:0] beat);
            zbf_pkg::res_t got, want;
            got.rejected   = beat[0];
            got.read_color = beat[8:1];
            got.read_depth = beat[40:9];
            if (pending_results.size() == 0)
            begin
                report_failure("unexpected result", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.rejected !== want.rejected || got.read_color !== want.read_color ||
                got.read_depth !== want.read_depth)
                report_failure("result mismatch", want, got);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [87:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [8:0]  cfg_data  = '0;

    bit tx_no_idle = 1'b1;
    bit rx_no_idle = 1'b1;

    zbuffer_scoreboard sb = new();

    zbuffered_box_fill #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Builds a request from plain values; used by the directed part.
    function automatic zbf_pkg::item_t request_of(zbf_pkg::op_t op, int x, int y, int w, int h,
                                                  logic [7:0] color, logic [31:0] depth);
        zbf_pkg::item_t req;
        req.op          = op;
        req.pos_x       = 11'(x);
        req.pos_y       = 11'(y);
        req.box_width   = 10'(w);
        req.box_height  = 10'(h);
        req.pixel_color = color;
        req.depth_value = depth;
        return req;
    endfunction

    // Random request for a frame of fw by fh entries. Depths are often drawn from a
    // narrow band so that the depth test both passes and fails.
    function automatic zbf_pkg::item_t random_request(int fw, int fh);
        zbf_pkg::item_t req;
        int             pick;
        bit             wide_frame;
        wide_frame = (fw * fh > WIDE_FRAME_ENTRIES);
        pick       = $urandom_range(0, 99);
        if (pick < 6 && !wide_frame)
            req.op = zbf_pkg::OP_CLEAR_ALL;
        else if (pick < 12 && !wide_frame)
            req.op = zbf_pkg::OP_CLEAR_DEPTH;
        else if (pick < 62)
            req.op = zbf_pkg::OP_BOX_FILL;
        else
            req.op = zbf_pkg::OP_READ;

        if (req.op == zbf_pkg::OP_READ && $urandom_range(0, 4) != 0)
        begin
            req.pos_x = 11'($urandom_range(0, fw - 1));
            req.pos_y = 11'($urandom_range(0, fh - 1));
        end
        else if ($urandom_range(0, 2) != 0)
        begin
            req.pos_x = 11'(int'($urandom_range(0, fw + 6)) - 4);
            req.pos_y = 11'(int'($urandom_range(0, fh + 6)) - 4);
        end
        else
        begin
            req.pos_x = 11'($urandom);
            req.pos_y = 11'($urandom);
        end

        if (wide_frame)
        begin
            req.box_width  = 10'($urandom_range(0, 15));
            req.box_height = 10'($urandom_range(0, 15));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    req.box_width  = 10'($urandom);
                    req.box_height = 10'($urandom);
                end
                1:
                begin
                    req.box_width  = 10'($urandom_range(0, 4));
                    req.box_height = 10'($urandom_range(0, 4));
                end
                default:
                begin
                    req.box_width  = 10'($urandom_range(0, fw + 3));
                    req.box_height = 10'($urandom_range(0, fh + 3));
                end
            endcase
        end

        req.pixel_color = 8'($urandom);
        case ($urandom_range(0, 3))
            0:
                req.depth_value = 32'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       req.depth_value = 32'h8000_0000;
                    1:       req.depth_value = 32'h7FFF_FFFF;
                    2:       req.depth_value = '0;
                    default: req.depth_value = '1;
                endcase
            end
            default:
                req.depth_value = 32'(int'($urandom_range(0, 127)) - 64);
        endcase
        return req;
    endfunction

    // Offers one request after a random gap and returns once it has been accepted.
    // tvalid is left high so that a back-to-back request needs no second assignment.
    task automatic send_request(input zbf_pkg::item_t req);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {4'b0, req.depth_value, req.pixel_color, req.box_height,
                     req.box_width, req.pos_y, req.pos_x, req.op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [8:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, val);
    endtask

    task automatic write_frame(input logic [8:0] wv, input logic [8:0] hv);
        wait_until_idle();
        write_register(REG_FRAME_WIDTH, wv);
        write_register(REG_FRAME_HEIGHT, hv);
        cfg_valid <= 1'b0;
    endtask

    // One frame setting followed by a run of random requests.
    task automatic run_phase(input logic [8:0] wv, input logic [8:0] hv, input int count);
        int fw, fh, n;
        write_frame(wv, hv);
        fw         = sb.frame_dim(wv, FRAME_MAX_W);
        fh         = sb.frame_dim(hv, FRAME_MAX_H);
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
        for (n = 0; n < count; n++)
        begin
            send_request(random_request(fw, fh));
            // Now and then hold off until the block has drained completely.
            if ($urandom_range(0, 49) == 0)
                wait_until_idle();
        end
    endtask

    // Result side: random stalls before each result, checked as it is taken.
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_no_idle ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata);
        end
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Clear the full 256 by 256 frame at the reset setting, so that every entry
        // is written before any later frame size reads it.
        send_request(request_of(zbf_pkg::OP_CLEAR_ALL, 0, 0, 0, 0, 8'hA5, 32'h7FFF_FFFF));
        write_frame(9'd8, 9'd6);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;

        // Plain box, then reads inside it and just beside it.
        send_request(request_of(zbf_pkg::OP_BOX_FILL, 1, 1, 3, 2, 8'h3C, 32'd100));
        send_request(request_of(zbf_pkg::OP_READ, 1, 1, 0, 0, 8'h00, 32'd0));
        send_request(request_of(zbf_pkg::OP_READ, 3, 2, 0, 0, 8'h00, 32'd0));
        send_request(request_of(zbf_pkg::OP_READ, 4, 1, 0, 0, 8'h00, 32'd0));
        // Equal depth must not overwrite.
        send_request(request_of(zbf_pkg::OP_BOX_FILL, 1, 1, 3, 2, 8'hFF, 32'd100));
        send_request(request_of(zbf_pkg::OP_READ, 1, 1, 0, 0, 8'h00, 32'd0));
        // Negative origin clipped to the frame, negative depth wins the signed compare.
        send_request(request_of(zbf_pkg::OP_BOX_FILL, -2, -3, 4, 5, 8'h11, -5));
        send_request(request_of(zbf_pkg::OP_READ, 0, 0, 0, 0, 8'h00, 32'd0));
        // Boxes wholly outside are rejected; one touching the left edge is empty only.
        send_request(request_of(zbf_pkg::OP_BOX_FILL, 8, 0, 5, 5, 8'h22, 32'd0));
        send_request(request_of(zbf_pkg::OP_BOX_FILL, 0, 6, 5, 5, 8'h22, 32'd0));
        send_request(request_of(zbf_pkg::OP_BOX_FILL, -5, 0, 4, 3, 8'h22, 32'd0));
        send_request(request_of(zbf_pkg::OP_BOX_FILL, -4, 0, 4, 3, 8'h22, 32'h8000_0000));
        send_request(request_of(zbf_pkg::OP_BOX_FILL, -1024, -1024, 1023, 1023, 8'h22, 32'd0));
        // Oversized box: the last column and row of the frame stay as they were.
        send_request(request_of(zbf_pkg::OP_BOX_FILL, 0, 0, 1023, 1023, 8'h00, 32'h8000_0000));
        send_request(request_of(zbf_pkg::OP_READ, 7, 5, 0, 0, 8'h00, 32'd0));
        send_request(request_of(zbf_pkg::OP_READ, 6, 4, 0, 0, 8'h00, 32'd0));
        // Reads outside the frame answer zero.
        send_request(request_of(zbf_pkg::OP_READ, -1, 0, 0, 0, 8'h00, 32'd0));
        send_request(request_of(zbf_pkg::OP_READ, 8, 0, 0, 0, 8'h00, 32'd0));
        send_request(request_of(zbf_pkg::OP_READ, 1023, 1023, 0, 0, 8'h00, 32'd0));
        send_request(request_of(zbf_pkg::OP_READ, -1024, -1024, 0, 0, 8'h00, 32'd0));
        // Depth-only clear leaves the colours alone.
        send_request(request_of(zbf_pkg::OP_CLEAR_DEPTH, 0, 0, 0, 0, 8'hFF, 32'h1234_5678));
        send_request(request_of(zbf_pkg::OP_READ, 0, 0, 0, 0, 8'h00, 32'd0));

        // Random phases over a spread of frame sizes, zero and oversized values included.
        // Each resize reinterprets the stored contents under the new width.
        run_phase(9'd1, 9'd1, 40);
        run_phase(9'd0, 9'd5, 40);
        run_phase(9'd511, 9'd2, 60);
        run_phase(9'd3, 9'd300, 60);
        repeat (6)
            run_phase(9'($urandom_range(2, 24)), 9'($urandom_range(2, 24)), 65);
        run_phase(9'd40, 9'd40, 40);
        run_phase(9'd256, 9'd256, 40);

        wait_until_idle();
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("tb_zbuffered_box_fill OK");
        else
            $display("tb_zbuffered_box_fill NOT OK");
        $finish;
    end

    // Several times the slowest legal run.
    initial
    begin : watchdog
        #40ms;
        $display("tb_zbuffered_box_fill NOT OK");
        $finish;
    end

endmodule
